// ===== rtl/core/tbo_pkg.sv =====
// Shared types and constants for the triangle / box overlap pipeline.
package tbo_pkg;

  // coordinate width and the growth of each arithmetic step
  localparam int CW   = 16;           // vertex and box coordinates
  localparam int EW   = CW + 1;       // triangle edges
  localparam int AW   = CW + 2;       // components of edge x box-normal axes
  localparam int PXW  = CW + AW;      // one product on a cross axis
  localparam int SXW  = PXW + 2;      // projection on a cross axis
  localparam int NPW  = 2 * EW;       // one product of the normal cross
  localparam int NW   = NPW + 1;      // triangle normal component
  localparam int NDW  = CW + NW;      // one product on the normal axis
  localparam int NSW  = NDW + 2;      // projection on the normal axis

  localparam int NCOORD = 9;          // coordinates per triangle
  localparam int NXAX   = 9;          // edge x box-normal axes
  localparam int NAXES  = 13;

  // pipeline depth
  localparam int NSTG   = 6;

  // axis numbering
  localparam logic [3:0] AXIS_NORMAL = 4'd3;
  localparam logic [3:0] AXIS_CROSS0 = 4'd4;
  localparam logic [3:0] AXIS_NONE   = 4'd13;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef logic signed [CW-1:0] coord_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic ld6;
    logic ld5;
    logic ld4;
    logic ld3;
    logic ld2;
    logic ld1;
  } stage_en_t;

endpackage

// ===== rtl/core/tbo_datapath.sv =====
// Six-stage arithmetic datapath of the separating axis test.
module tbo_datapath (
  input  logic                    clk,
  input  tbo_pkg::stage_en_t      en,
  input  tbo_pkg::coord_t         vin   [tbo_pkg::NCOORD],
  input  tbo_pkg::coord_t         bmin  [3],
  input  tbo_pkg::coord_t         bmax  [3],
  output logic                    overlap,
  output logic [3:0]              sep_axis
);

  typedef logic signed [tbo_pkg::EW-1:0]  edge_t;
  typedef logic signed [tbo_pkg::AW-1:0]  axc_t;
  typedef logic signed [tbo_pkg::PXW-1:0] xprod_t;
  typedef logic signed [tbo_pkg::SXW-1:0] xsum_t;
  typedef logic signed [tbo_pkg::NPW-1:0] nprod_t;
  typedef logic signed [tbo_pkg::NW-1:0]  normal_t;
  typedef logic signed [tbo_pkg::NDW-1:0] ndot_t;
  typedef logic signed [tbo_pkg::NSW-1:0] nsum_t;

  // interval test at the widest width: hi below triangle min or triangle max below lo
  function automatic logic sep_test(nsum_t p0, nsum_t p1, nsum_t p2, nsum_t lo, nsum_t hi);
    nsum_t tmin;
    nsum_t tmax;
    tmin = p0;
    tmax = p0;
    if (p1 < tmin) tmin = p1;
    if (p1 > tmax) tmax = p1;
    if (p2 < tmin) tmin = p2;
    if (p2 > tmax) tmax = p2;
    return (hi < tmin) || (tmax < lo);
  endfunction

  // ---------------- stage 1: vertices and edges
  tbo_pkg::coord_t v1_r [tbo_pkg::NCOORD];
  edge_t           e1_r [tbo_pkg::NCOORD];

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          v1_r[i*3+c] <= vin[i*3+c];
          // e_i = v_(i+1) - v_i, wrapping to v0 after v2
          if (i == 2) begin
            e1_r[i*3+c] <= edge_t'(vin[c]) - edge_t'(vin[i*3+c]);
          end else begin
            e1_r[i*3+c] <= edge_t'(vin[(i+1)*3+c]) - edge_t'(vin[i*3+c]);
          end
        end
      end
    end
  end

  // ---------------- stage 2: products
  axc_t ax1 [tbo_pkg::NXAX][3];

  // build axes cross(n, e_i) for box normal n and edge e_i
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      for (int i = 0; i < 3; i++) begin
        unique case (n)
          0: begin
            ax1[n*3+i][0] = '0;
            ax1[n*3+i][1] = -axc_t'(e1_r[i*3+2]);
            ax1[n*3+i][2] = axc_t'(e1_r[i*3+1]);
          end
          1: begin
            ax1[n*3+i][0] = axc_t'(e1_r[i*3+2]);
            ax1[n*3+i][1] = '0;
            ax1[n*3+i][2] = -axc_t'(e1_r[i*3+0]);
          end
          default: begin
            ax1[n*3+i][0] = -axc_t'(e1_r[i*3+1]);
            ax1[n*3+i][1] = axc_t'(e1_r[i*3+0]);
            ax1[n*3+i][2] = '0;
          end
        endcase
      end
    end
  end

  xprod_t          pv2_r  [tbo_pkg::NXAX][3][3];
  xprod_t          plo2_r [tbo_pkg::NXAX][3];
  xprod_t          phi2_r [tbo_pkg::NXAX][3];
  nprod_t          np2_r  [6];
  tbo_pkg::coord_t v2_r   [tbo_pkg::NCOORD];
  logic [2:0]      sepb2_r;

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      for (int k = 0; k < tbo_pkg::NXAX; k++) begin
        for (int c = 0; c < 3; c++) begin
          for (int j = 0; j < 3; j++) begin
            pv2_r[k][j][c] <= xprod_t'(v1_r[j*3+c]) * xprod_t'(ax1[k][c]);
          end
          // negative component swaps the box corners
          if (ax1[k][c][tbo_pkg::AW-1]) begin
            plo2_r[k][c] <= xprod_t'(bmax[c]) * xprod_t'(ax1[k][c]);
            phi2_r[k][c] <= xprod_t'(bmin[c]) * xprod_t'(ax1[k][c]);
          end else begin
            plo2_r[k][c] <= xprod_t'(bmin[c]) * xprod_t'(ax1[k][c]);
            phi2_r[k][c] <= xprod_t'(bmax[c]) * xprod_t'(ax1[k][c]);
          end
        end
      end
      // normal = cross(e0, e1)
      np2_r[0] <= nprod_t'(e1_r[1]) * nprod_t'(e1_r[5]);
      np2_r[1] <= nprod_t'(e1_r[2]) * nprod_t'(e1_r[4]);
      np2_r[2] <= nprod_t'(e1_r[2]) * nprod_t'(e1_r[3]);
      np2_r[3] <= nprod_t'(e1_r[0]) * nprod_t'(e1_r[5]);
      np2_r[4] <= nprod_t'(e1_r[0]) * nprod_t'(e1_r[4]);
      np2_r[5] <= nprod_t'(e1_r[1]) * nprod_t'(e1_r[3]);
      // box normals test the coordinates directly
      for (int c = 0; c < 3; c++) begin
        sepb2_r[c] <= sep_test(nsum_t'(v1_r[c]), nsum_t'(v1_r[3+c]), nsum_t'(v1_r[6+c]),
                               nsum_t'(bmin[c]), nsum_t'(bmax[c]));
      end
      v2_r <= v1_r;
    end
  end

  // ---------------- stage 3: cross-axis projections, triangle normal
  xsum_t           px3_r [tbo_pkg::NXAX][3];
  xsum_t           lo3_r [tbo_pkg::NXAX];
  xsum_t           hi3_r [tbo_pkg::NXAX];
  normal_t         n3_r  [3];
  tbo_pkg::coord_t v3_r  [tbo_pkg::NCOORD];
  logic [2:0]      sepb3_r;

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      for (int k = 0; k < tbo_pkg::NXAX; k++) begin
        for (int j = 0; j < 3; j++) begin
          px3_r[k][j] <= xsum_t'(pv2_r[k][j][0]) + xsum_t'(pv2_r[k][j][1])
                       + xsum_t'(pv2_r[k][j][2]);
        end
        lo3_r[k] <= xsum_t'(plo2_r[k][0]) + xsum_t'(plo2_r[k][1]) + xsum_t'(plo2_r[k][2]);
        hi3_r[k] <= xsum_t'(phi2_r[k][0]) + xsum_t'(phi2_r[k][1]) + xsum_t'(phi2_r[k][2]);
      end
      n3_r[0] <= normal_t'(np2_r[0]) - normal_t'(np2_r[1]);
      n3_r[1] <= normal_t'(np2_r[2]) - normal_t'(np2_r[3]);
      n3_r[2] <= normal_t'(np2_r[4]) - normal_t'(np2_r[5]);
      v3_r    <= v2_r;
      sepb3_r <= sepb2_r;
    end
  end

  // ---------------- stage 4: cross-axis tests, normal products
  ndot_t                   nd4_r  [3][3];
  ndot_t                   nlo4_r [3];
  ndot_t                   nhi4_r [3];
  logic [tbo_pkg::NXAX-1:0] sepx4_r;
  logic [2:0]              sepb4_r;

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      for (int k = 0; k < tbo_pkg::NXAX; k++) begin
        sepx4_r[k] <= sep_test(nsum_t'(px3_r[k][0]), nsum_t'(px3_r[k][1]),
                               nsum_t'(px3_r[k][2]), nsum_t'(lo3_r[k]), nsum_t'(hi3_r[k]));
      end
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          nd4_r[j][c] <= ndot_t'(v3_r[j*3+c]) * ndot_t'(n3_r[c]);
        end
        if (n3_r[c][tbo_pkg::NW-1]) begin
          nlo4_r[c] <= ndot_t'(bmax[c]) * ndot_t'(n3_r[c]);
          nhi4_r[c] <= ndot_t'(bmin[c]) * ndot_t'(n3_r[c]);
        end else begin
          nlo4_r[c] <= ndot_t'(bmin[c]) * ndot_t'(n3_r[c]);
          nhi4_r[c] <= ndot_t'(bmax[c]) * ndot_t'(n3_r[c]);
        end
      end
      sepb4_r <= sepb3_r;
    end
  end

  // ---------------- stage 5: normal-axis projections
  nsum_t                    tn5_r [3];
  nsum_t                    lo5_r;
  nsum_t                    hi5_r;
  logic [tbo_pkg::NXAX-1:0] sepx5_r;
  logic [2:0]               sepb5_r;

  always_ff @(posedge clk) begin
    if (en.ld5) begin
      for (int j = 0; j < 3; j++) begin
        tn5_r[j] <= nsum_t'(nd4_r[j][0]) + nsum_t'(nd4_r[j][1]) + nsum_t'(nd4_r[j][2]);
      end
      lo5_r   <= nsum_t'(nlo4_r[0]) + nsum_t'(nlo4_r[1]) + nsum_t'(nlo4_r[2]);
      hi5_r   <= nsum_t'(nhi4_r[0]) + nsum_t'(nhi4_r[1]) + nsum_t'(nhi4_r[2]);
      sepx5_r <= sepx4_r;
      sepb5_r <= sepb4_r;
    end
  end

  // ---------------- stage 6: normal test and first separating axis
  logic [tbo_pkg::NAXES-1:0] sep_all;
  logic [3:0]                first_axis;

  always_comb begin
    sep_all = {sepx5_r, sep_test(tn5_r[0], tn5_r[1], tn5_r[2], lo5_r, hi5_r), sepb5_r};
    first_axis = tbo_pkg::AXIS_NONE;
    for (int k = tbo_pkg::NAXES - 1; k >= 0; k--) begin
      if (sep_all[k]) first_axis = 4'(k);
    end
  end

  logic       overlap_r;
  logic [3:0] axis_r;

  always_ff @(posedge clk) begin
    if (en.ld6) begin
      overlap_r <= (first_axis == tbo_pkg::AXIS_NONE);
      axis_r    <= first_axis;
    end
  end

  assign overlap  = overlap_r;
  assign sep_axis = axis_r;

endmodule

// ===== rtl/core/triangle_box_overlap_sat_top.sv =====
// Top level: triangle versus axis-aligned box overlap by the separating axis test.
//
// Each input beat carries one triangle (nine signed 16-bit coordinates); each output
// beat gives the overlap flag and the first separating axis of the 13 tried (0..2 box
// normals, 3 triangle normal, 4..12 box normal x edge; 13 when none separates).
// Touching counts as overlap. The box corners sit in six configuration registers; the
// user must write them only while no triangle is in flight, as the block itself does
// not enforce it. The datapath is a six-stage pipeline that takes one triangle per cycle;
// its depth is set by the two multiply/sum rounds of the triangle normal. Back-pressure
// holds each stage in place, and empty stages still fill while the output waits.
module triangle_box_overlap_sat_top (
  input  logic         clk,
  input  logic         rst_n,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (16 bits each, from bit 0)
  input  logic [143:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // overlap [0], separating_axis [4:1], zero [7:5]
  output logic [7:0]   out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // box registers
  tbo_pkg::coord_t bmin_r [3];
  tbo_pkg::coord_t bmax_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        bmin_r[c] <= '0;
        bmax_r[c] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (tbo_pkg::cfg_reg_t'(cfg_index))
        tbo_pkg::REG_BOX_MIN_X: bmin_r[0] <= cfg_data;
        tbo_pkg::REG_BOX_MIN_Y: bmin_r[1] <= cfg_data;
        tbo_pkg::REG_BOX_MIN_Z: bmin_r[2] <= cfg_data;
        tbo_pkg::REG_BOX_MAX_X: bmax_r[0] <= cfg_data;
        tbo_pkg::REG_BOX_MAX_Y: bmax_r[1] <= cfg_data;
        tbo_pkg::REG_BOX_MAX_Z: bmax_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits per stage; a stage loads when empty or when the next one moves
  logic [tbo_pkg::NSTG-1:0] vld_r;
  logic [tbo_pkg::NSTG:0]   adv;

  always_comb begin
    adv[tbo_pkg::NSTG] = out_tready;
    for (int s = tbo_pkg::NSTG - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < tbo_pkg::NSTG; s++) begin
        if (adv[s]) begin
          if (s == 0) vld_r[s] <= in_tvalid;
          else        vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  tbo_pkg::stage_en_t en;
  assign en = '{ld6: adv[5], ld5: adv[4], ld4: adv[3], ld3: adv[2], ld2: adv[1], ld1: adv[0]};

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[tbo_pkg::NSTG-1];

  // unpack the vertex beat
  tbo_pkg::coord_t vin [tbo_pkg::NCOORD];

  always_comb begin
    for (int i = 0; i < tbo_pkg::NCOORD; i++) begin
      vin[i] = in_tdata[i*tbo_pkg::CW +: tbo_pkg::CW];
    end
  end

  logic       overlap;
  logic [3:0] sep_axis;

  tbo_datapath u_datapath (
    .clk      (clk),
    .en       (en),
    .vin      (vin),
    .bmin     (bmin_r),
    .bmax     (bmax_r),
    .overlap  (overlap),
    .sep_axis (sep_axis)
  );

  assign out_tdata = {3'b000, sep_axis, overlap};

endmodule

// ===== rtl/core/tbo_checker.sv =====
// Port-level checker for the overlap block, bound to the top level.
module tbo_checker (
  input logic       clk,
  input logic       rst_n,
  input logic [7:0] out_tdata,
  input logic       out_tvalid,
  input logic       out_tready
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

  // overlap flag agrees with the axis code
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == tbo_pkg::AXIS_NONE)))
    else $error("overlap flag and axis disagree");

  // axis code in range and padding clear
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:1] <= tbo_pkg::AXIS_NONE) && (out_tdata[7:5] == 3'b000))
    else $error("axis code out of range");

  // pipeline empties on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind triangle_box_overlap_sat_top tbo_checker u_tbo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
